>>> design/speed_scale_interval_limits_core_defines.svh
// Assertion macros shared by the core.
`ifndef SPEED_SCALE_INTERVAL_LIMITS_CORE_DEFINES_SVH
`define SPEED_SCALE_INTERVAL_LIMITS_CORE_DEFINES_SVH

// Same-cycle implication.
`define SSIL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSIL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sssil_pkg.sv
package sssil_pkg;

  localparam int unsigned OPC_W = 2;
  localparam int unsigned TOL_W = 16;

  typedef struct packed {
    logic skip;
    logic last;
    logic unit;
  } job_flags_t;

endpackage

>>> design/speed_scale_interval_limits_core.sv
// Channel  | Direction | Contents
// s_axis   | in        | tdata: joint vel/acc/jerk/limit, scale, rate; tuser: opcode; tlast
// m_axis   | out       | tdata: lower_bound, upper_bound
// APB      | in/out    | reg 0 clamp_to_unit_range, reg 1 zero_tolerance
//
// Front takes a new word only after it has pushed its current job to the queue.
// Back divides both bounds serially and emits the running bounds after a last joint.
// Skipped joints bypass the front multiplier and the back divider.
// A 2-entry queue decouples front and back; output stalls reach the front once it is full.
// Reset clears control state and the running bounds; no clearing pass.
module speed_scale_interval_limits_core #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // vel, acc, jerk, limit (DATA_WIDTH-1), scale, rate, zero pad
  input  logic [((6*DATA_WIDTH-1+7)/8)*8-1:0]        s_axis_tdata,
  // opcode
  input  logic [sssil_pkg::OPC_W-1:0]                s_axis_tuser,
  input  logic                                       s_axis_tlast,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // lower_bound, upper_bound, zero pad
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [2:0]                                 paddr,
  input  logic [31:0]                                pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  import sssil_pkg::*;

  localparam int unsigned DW     = DATA_WIDTH;
  localparam int unsigned OUT_TW = ((2*DW + 7) / 8) * 8;
  localparam int unsigned JOB_W  = $bits(job_flags_t) + 3*DW;

  typedef enum logic {
    REG_CLAMP     = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_idx_e;

  logic             clamp_q;
  logic [TOL_W-1:0] tol_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  job_flags_t       f_flags;
  logic             f_valid;
  logic             f_ready;
  logic [DW-1:0]    f_vel;
  logic [DW-1:0]    f_num_lo;
  logic [DW-1:0]    f_num_hi;
  logic [JOB_W-1:0] q_data;
  logic             q_valid;
  logic             q_ready;
  job_flags_t       b_flags;
  logic [DW-1:0]    b_vel;
  logic [DW-1:0]    b_num_lo;
  logic [DW-1:0]    b_num_hi;
  logic [DW-1:0]    lower;
  logic [DW-1:0]    upper;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= 1'b0;
      tol_q   <= TOL_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CLAMP:     clamp_q <= pwdata[0];
        REG_TOLERANCE: tol_q   <= pwdata[TOL_W-1:0];
        default:       clamp_q <= clamp_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CLAMP:     prdata = {31'b0, clamp_q};
      REG_TOLERANCE: prdata = {{(32-TOL_W){1'b0}}, tol_q};
      default:       prdata = '0;
    endcase
  end

  sssil_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .vel_i       (s_axis_tdata[0 +: DW]),
    .acc_i       (s_axis_tdata[DW +: DW]),
    .jerk_i      (s_axis_tdata[2*DW +: DW]),
    .lim_i       (s_axis_tdata[3*DW +: DW-1]),
    .scale_i     (s_axis_tdata[4*DW-1 +: DW]),
    .rate_i      (s_axis_tdata[5*DW-1 +: DW]),
    .last_i      (s_axis_tlast),
    .tol_i       (tol_q),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_flags_o (f_flags),
    .job_vel_o   (f_vel),
    .job_num_lo_o(f_num_lo),
    .job_num_hi_o(f_num_hi)
  );

  sssil_fifo #(
    .WIDTH(JOB_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i ({f_flags, f_vel, f_num_hi, f_num_lo}),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_data)
  );

  assign {b_flags, b_vel, b_num_hi, b_num_lo} = q_data;

  sssil_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_flags_i (b_flags),
    .job_vel_i   (b_vel),
    .job_num_lo_i(b_num_lo),
    .job_num_hi_i(b_num_hi),
    .clamp_i     (clamp_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .lower_o     (lower),
    .upper_o     (upper)
  );

  assign m_axis_tdata = OUT_TW'({upper, lower});

endmodule

>>> design/sssil_mul.sv
module sssil_mul #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] p_o
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned CHUNK = 16;
  localparam int unsigned NCH   = (DW + CHUNK - 1) / CHUNK;
  localparam int unsigned MW    = NCH * CHUNK;
  localparam int unsigned PW    = DW + MW;
  localparam int unsigned CW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [DW-1:0] abs_fn(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + {{(DW-1){1'b0}}, 1'b1}) : x;
  endfunction

  logic                busy_q;
  logic                done_q;
  logic                neg_q;
  logic [CW-1:0]       cnt_q;
  logic [DW-1:0]       ma_q;
  logic [PW-1:0]       prod_q;
  logic [DW+CHUNK-1:0] sum;
  logic [PW+CHUNK-1:0] cat;
  logic [PW-1:0]       shr;
  logic                ovf;
  logic [DW-1:0]       mag;

  assign sum = {{CHUNK{1'b0}}, prod_q[PW-1:MW]}
             + ({{CHUNK{1'b0}}, ma_q} * {{DW{1'b0}}, prod_q[CHUNK-1:0]});
  assign cat = {sum, prod_q[MW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      ma_q   <= '0;
      prod_q <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(NCH - 1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        neg_q  <= a_i[DW-1] ^ b_i[DW-1];
        cnt_q  <= '0;
        ma_q   <= abs_fn(a_i);
        prod_q <= PW'(abs_fn(b_i));
      end else if (busy_q) begin
        prod_q <= cat[PW+CHUNK-1:CHUNK];
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CW'(NCH - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign shr = prod_q >> FRAC_BITS;
  assign ovf = |(shr >> (DW - 1));
  assign mag = shr[DW-1:0];

  always_comb begin
    if (ovf || mag[DW-1]) begin
      p_o = neg_q ? VMIN : VMAX;
    end else begin
      p_o = neg_q ? (~mag + {{(DW-1){1'b0}}, 1'b1}) : mag;
    end
  end

  assign done_o = done_q;

endmodule

>>> design/sssil_front.sv
module sssil_front #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sssil_pkg::OPC_W-1:0] opcode_i,
  input  logic [DATA_WIDTH-1:0]       vel_i,
  input  logic [DATA_WIDTH-1:0]       acc_i,
  input  logic [DATA_WIDTH-1:0]       jerk_i,
  input  logic [DATA_WIDTH-2:0]       lim_i,
  input  logic [DATA_WIDTH-1:0]       scale_i,
  input  logic [DATA_WIDTH-1:0]       rate_i,
  input  logic                        last_i,
  input  logic [sssil_pkg::TOL_W-1:0] tol_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output sssil_pkg::job_flags_t       job_flags_o,
  output logic [DATA_WIDTH-1:0]       job_vel_o,
  output logic [DATA_WIDTH-1:0]       job_num_lo_o,
  output logic [DATA_WIDTH-1:0]       job_num_hi_o
);

  import sssil_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [OPC_W-1:0] {
    OP_VEL  = 2'd0,
    OP_ACC  = 2'd1,
    OP_JERK = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S2,
    ST_OFF_ACC,
    ST_S3,
    ST_JS3,
    ST_AR,
    ST_ARS,
    ST_SUM1,
    ST_SUM2,
    ST_SUM3,
    ST_BOUND,
    ST_PUSH
  } state_e;

  function automatic logic [DW-1:0] abs_fn(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + {{(DW-1){1'b0}}, 1'b1}) : x;
  endfunction

  function automatic logic [DW-1:0] sat_fit(input logic [DW:0] s);
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? VMIN : VMAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return sat_fit({a[DW-1], a} + {b[DW-1], b});
  endfunction

  function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return sat_fit({a[DW-1], a} - {b[DW-1], b});
  endfunction

  state_e           state_q;
  logic             wait_q;
  logic [OPC_W-1:0] opcode_q;
  logic [DW-1:0]    vel_q;
  logic [DW-1:0]    acc_q;
  logic [DW-1:0]    jerk_q;
  logic [DW-2:0]    lim_q;
  logic [DW-1:0]    scale_q;
  logic [DW-1:0]    rate_q;
  logic             last_q;
  logic             skip_q;
  logic [DW-1:0]    s2_q;
  logic [DW-1:0]    jt_q;
  logic [DW-1:0]    t_q;
  logic [DW-1:0]    off_q;
  logic [DW-1:0]    num_lo_q;
  logic [DW-1:0]    num_hi_q;

  logic             is_mul;
  logic             mul_start;
  logic [DW-1:0]    mul_a;
  logic [DW-1:0]    mul_b;
  logic             mul_done;
  logic [DW-1:0]    mul_p;
  logic             in_skip;
  logic [DW-1:0]    lim_ext;
  logic [DW-1:0]    rhs;
  logic [DW-1:0]    lhs;

  assign is_mul = (state_q == ST_S2) || (state_q == ST_OFF_ACC) || (state_q == ST_S3)
               || (state_q == ST_JS3) || (state_q == ST_AR) || (state_q == ST_ARS);
  assign mul_start = is_mul && !wait_q;

  always_comb begin
    unique case (state_q)
      ST_S2: begin
        mul_a = scale_q;
        mul_b = scale_q;
      end
      ST_OFF_ACC: begin
        mul_a = acc_q;
        mul_b = s2_q;
      end
      ST_S3: begin
        mul_a = s2_q;
        mul_b = scale_q;
      end
      ST_JS3: begin
        mul_a = jerk_q;
        mul_b = jt_q;
      end
      ST_AR: begin
        mul_a = acc_q;
        mul_b = rate_q;
      end
      ST_ARS: begin
        mul_a = t_q;
        mul_b = scale_q;
      end
      default: begin
        mul_a = scale_q;
        mul_b = scale_q;
      end
    endcase
  end

  sssil_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign in_skip = (vel_i == '0) || (abs_fn(vel_i) < DW'(tol_i));
  assign lim_ext = {1'b0, lim_q};
  assign rhs     = sat_sub(lim_ext, off_q);
  assign lhs     = sat_sub(~lim_ext + {{(DW-1){1'b0}}, 1'b1}, off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wait_q   <= 1'b0;
      opcode_q <= '0;
      vel_q    <= '0;
      acc_q    <= '0;
      jerk_q   <= '0;
      lim_q    <= '0;
      scale_q  <= '0;
      rate_q   <= '0;
      last_q   <= 1'b0;
      skip_q   <= 1'b0;
      s2_q     <= '0;
      jt_q     <= '0;
      t_q      <= '0;
      off_q    <= '0;
      num_lo_q <= '0;
      num_hi_q <= '0;
    end else begin
      if (is_mul) begin
        if (!wait_q) begin
          wait_q <= 1'b1;
        end else if (mul_done) begin
          wait_q <= 1'b0;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            opcode_q <= opcode_i;
            vel_q    <= vel_i;
            acc_q    <= acc_i;
            jerk_q   <= jerk_i;
            lim_q    <= lim_i;
            scale_q  <= scale_i;
            rate_q   <= rate_i;
            last_q   <= last_i;
            skip_q   <= in_skip;
            off_q    <= '0;
            if (in_skip) begin
              state_q <= ST_PUSH;
            end else if (opcode_i == OP_ACC || opcode_i == OP_JERK) begin
              state_q <= ST_S2;
            end else begin
              state_q <= ST_BOUND;
            end
          end
        end
        ST_S2: begin
          if (wait_q && mul_done) begin
            s2_q    <= mul_p;
            state_q <= (opcode_q == OP_ACC) ? ST_OFF_ACC : ST_S3;
          end
        end
        ST_OFF_ACC: begin
          if (wait_q && mul_done) begin
            off_q   <= mul_p;
            state_q <= ST_BOUND;
          end
        end
        ST_S3: begin
          if (wait_q && mul_done) begin
            jt_q    <= mul_p;
            state_q <= ST_JS3;
          end
        end
        ST_JS3: begin
          if (wait_q && mul_done) begin
            jt_q    <= mul_p;
            state_q <= ST_AR;
          end
        end
        ST_AR: begin
          if (wait_q && mul_done) begin
            t_q     <= mul_p;
            state_q <= ST_ARS;
          end
        end
        ST_ARS: begin
          if (wait_q && mul_done) begin
            t_q     <= mul_p;
            state_q <= ST_SUM1;
          end
        end
        ST_SUM1: begin
          off_q   <= sat_add(t_q, t_q);
          state_q <= ST_SUM2;
        end
        ST_SUM2: begin
          off_q   <= sat_add(off_q, t_q);
          state_q <= ST_SUM3;
        end
        ST_SUM3: begin
          off_q   <= sat_add(jt_q, off_q);
          state_q <= ST_BOUND;
        end
        ST_BOUND: begin
          // negative velocity swaps the bounds
          num_lo_q <= vel_q[DW-1] ? rhs : lhs;
          num_hi_q <= vel_q[DW-1] ? lhs : rhs;
          state_q  <= ST_PUSH;
        end
        ST_PUSH: begin
          if (job_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign job_valid_o      = (state_q == ST_PUSH);
  assign job_flags_o.skip = skip_q;
  assign job_flags_o.last = last_q;
  assign job_flags_o.unit = (opcode_q == OP_VEL);
  assign job_vel_o        = vel_q;
  assign job_num_lo_o     = num_lo_q;
  assign job_num_hi_o     = num_hi_q;

endmodule

>>> design/sssil_fifo.sv
module sssil_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != (PTR_W + 1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> design/sssil_back.sv
`include "speed_scale_interval_limits_core_defines.svh"

module sssil_back #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_ready_o,
  input  sssil_pkg::job_flags_t job_flags_i,
  input  logic [DATA_WIDTH-1:0] job_vel_i,
  input  logic [DATA_WIDTH-1:0] job_num_lo_i,
  input  logic [DATA_WIDTH-1:0] job_num_hi_i,
  input  logic                  clamp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] lower_o,
  output logic [DATA_WIDTH-1:0] upper_o
);

  import sssil_pkg::*;

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned NW    = DW + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NW);
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  =
    (FRAC_BITS < DW - 1) ? (DW'(1) << FRAC_BITS) : VMAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } state_e;

  function automatic logic [DW-1:0] abs_fn(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + {{(DW-1){1'b0}}, 1'b1}) : x;
  endfunction

  function automatic logic [DW-1:0] quo_sat(input logic [NW-1:0] q, input logic neg);
    logic big;
    big = |(q >> (DW - 1));
    if (big) begin
      return neg ? VMIN : VMAX;
    end
    return neg ? (~q[DW-1:0] + {{(DW-1){1'b0}}, 1'b1}) : q[DW-1:0];
  endfunction

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DW-1:0]         d_q;
  logic [DW-1:0]         rem_q [2];
  logic [NW-1:0]         dvd_q [2];
  logic [NW-1:0]         quo_q [2];
  logic                  neg_q [2];
  logic                  last_q;
  logic                  unit_q;
  logic signed [DW-1:0]  run_lo_q;
  logic signed [DW-1:0]  run_hi_q;
  logic                  out_valid_q;
  logic signed [DW-1:0]  out_lo_q;
  logic signed [DW-1:0]  out_hi_q;

  logic [DW:0]           trial [2];
  logic [DW-1:0]         rem_d [2];
  logic                  qbit  [2];
  logic signed [DW-1:0]  q_lo;
  logic signed [DW-1:0]  q_hi;
  logic                  out_free;
  logic                  emit_fire;
  logic                  do_clamp;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem_q[i], dvd_q[i][NW-1]};
      if (trial[i] >= {1'b0, d_q}) begin
        rem_d[i] = DW'(trial[i] - {1'b0, d_q});
        qbit[i]  = 1'b1;
      end else begin
        rem_d[i] = trial[i][DW-1:0];
        qbit[i]  = 1'b0;
      end
    end
  end

  assign q_lo      = quo_sat(quo_q[0], neg_q[0]);
  assign q_hi      = quo_sat(quo_q[1], neg_q[1]);
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_fire = (state_q == ST_EMIT) && out_free;
  assign do_clamp  = clamp_i && unit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      d_q         <= '0;
      last_q      <= 1'b0;
      unit_q      <= 1'b0;
      run_lo_q    <= VMIN;
      run_hi_q    <= VMAX;
      out_valid_q <= 1'b0;
      out_lo_q    <= '0;
      out_hi_q    <= '0;
      for (int i = 0; i < 2; i++) begin
        rem_q[i] <= '0;
        dvd_q[i] <= '0;
        quo_q[i] <= '0;
        neg_q[i] <= 1'b0;
      end
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            last_q   <= job_flags_i.last;
            unit_q   <= job_flags_i.unit;
            d_q      <= abs_fn(job_vel_i);
            cnt_q    <= '0;
            rem_q[0] <= '0;
            rem_q[1] <= '0;
            dvd_q[0] <= {abs_fn(job_num_lo_i), {FRAC_BITS{1'b0}}};
            dvd_q[1] <= {abs_fn(job_num_hi_i), {FRAC_BITS{1'b0}}};
            neg_q[0] <= job_num_lo_i[DW-1] ^ job_vel_i[DW-1];
            neg_q[1] <= job_num_hi_i[DW-1] ^ job_vel_i[DW-1];
            if (!job_flags_i.skip) begin
              state_q <= ST_DIV;
            end else if (job_flags_i.last) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          for (int i = 0; i < 2; i++) begin
            rem_q[i] <= rem_d[i];
            dvd_q[i] <= dvd_q[i] << 1;
            quo_q[i] <= {quo_q[i][NW-2:0], qbit[i]};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(NW - 1)) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (q_lo > run_lo_q) begin
            run_lo_q <= q_lo;
          end
          if (q_hi < run_hi_q) begin
            run_hi_q <= q_hi;
          end
          state_q <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_lo_q    <= (do_clamp && run_lo_q < 0) ? '0 : run_lo_q;
            out_hi_q    <= (do_clamp && run_hi_q > ONE) ? ONE : run_hi_q;
            run_lo_q    <= VMIN;
            run_hi_q    <= VMAX;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign job_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign lower_o     = out_lo_q;
  assign upper_o     = out_hi_q;

  `SSIL_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, state_q == ST_DIV, d_q != '0, "divide by zero")
  `SSIL_ASSERT_NEXT(a_emit_rearm, clk_i, rst_ni, emit_fire, run_lo_q == VMIN && run_hi_q == VMAX, "running bounds not rearmed")
  `SSIL_ASSERT_NEXT(a_clamp_range, clk_i, rst_ni, emit_fire && do_clamp, out_lo_q >= 0 && out_hi_q <= ONE, "clamped pair out of range")

endmodule

>>> dv/speed_scale_interval_limits_core_tb.sv
`timescale 1ns / 1ps

module speed_scale_interval_limits_core_tb;

  localparam int unsigned DW = 32;
  localparam int unsigned FW = 16;
  localparam int unsigned S_TDATA_W = ((6*DW-1+7)/8)*8;
  localparam int unsigned M_TDATA_W = ((2*DW+7)/8)*8;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 1500;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
  localparam logic [30:0] LIM_MAX = 31'h7fff_ffff;

  typedef enum logic [sssil_pkg::OPC_W-1:0] {
    OP_VEL   = 2'd0,
    OP_ACC   = 2'd1,
    OP_JERK  = 2'd2,
    OP_SPARE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    REG_CLAMP = 3'd0,
    REG_TOL   = 3'd4
  } reg_addr_e;

  typedef struct {
    opcode_e           op;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic signed [31:0] jerk;
    logic [30:0]        lim;
    logic signed [31:0] scale;
    logic signed [31:0] rate;
    logic               last;
  } joint_t;

  typedef struct {
    logic [31:0] lower;
    logic [31:0] upper;
  } interval_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // vel, acc, jerk, limit (31 bits), scale, rate, zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  // opcode
  logic [sssil_pkg::OPC_W-1:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // lower_bound, upper_bound
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  joint_t joint_queue[$];
  interval_t bounds_expected[$];
  joint_t held_joint;

  logic cfg_clamp = 1'b0;
  int unsigned cfg_tol = 1;
  longint run_lower = Q_MIN;
  longint run_upper = Q_MAX;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  speed_scale_interval_limits_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic longint sat(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    if (p < 0) return sat(-((-p) >>> FW));
    return sat(p >>> FW);
  endfunction

  function automatic longint qdiv(longint num, longint den);
    longint n;
    longint d;
    longint q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n << FW) / d;
    return sat(((num < 0) != (den < 0)) ? -q : q);
  endfunction

  function automatic void predict_joint(joint_t j);
    longint vel;
    longint acc;
    longint jerk;
    longint lim;
    longint sc;
    longint rate;
    longint off;
    longint rhs;
    longint lhs;
    longint lo;
    longint hi;
    longint sc3;
    longint t;
    interval_t res;
    vel = longint'(j.vel);
    acc = longint'(j.acc);
    jerk = longint'(j.jerk);
    lim = longint'(j.lim);
    sc = longint'(j.scale);
    rate = longint'(j.rate);
    case (j.op)
      OP_ACC: off = qmul(acc, qmul(sc, sc));
      OP_JERK: begin
        sc3 = qmul(qmul(sc, sc), sc);
        t = qmul(qmul(acc, rate), sc);
        off = sat(qmul(jerk, sc3) + sat(sat(t + t) + t));
      end
      default: off = 0;
    endcase
    rhs = sat(lim - off);
    lhs = sat(-lim - off);
    if (vel != 0 && ((vel < 0) ? -vel : vel) >= longint'(cfg_tol)) begin
      if (vel > 0) begin
        lo = qdiv(lhs, vel);
        hi = qdiv(rhs, vel);
      end else begin
        lo = qdiv(rhs, vel);
        hi = qdiv(lhs, vel);
      end
      if (lo > run_lower) run_lower = lo;
      if (hi < run_upper) run_upper = hi;
    end
    if (j.last) begin
      lo = run_lower;
      hi = run_upper;
      if (j.op == OP_VEL && cfg_clamp) begin
        if (lo < 0) lo = 0;
        if (hi > longint'(Q_ONE)) hi = longint'(Q_ONE);
      end
      res.lower = lo[31:0];
      res.upper = hi[31:0];
      bounds_expected.push_back(res);
      run_lower = Q_MIN;
      run_upper = Q_MAX;
    end
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // stream driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_joint(held_joint);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (joint_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_joint = joint_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, held_joint.rate, held_joint.scale, held_joint.lim,
                           held_joint.jerk, held_joint.acc, held_joint.vel};
          s_axis_tuser <= held_joint.op;
          s_axis_tlast <= held_joint.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk_i) begin
    interval_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (bounds_expected.size() == 0) begin
          $error("unexpected word: lower_bound %0d upper_bound %0d",
                 $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]));
          err_count++;
        end else begin
          want = bounds_expected.pop_front();
          if (m_axis_tdata[31:0] !== want.lower) begin
            $error("lower_bound: expected %0d, got %0d",
                   $signed(want.lower), $signed(m_axis_tdata[31:0]));
            err_count++;
          end
          if (m_axis_tdata[63:32] !== want.upper) begin
            $error("upper_bound: expected %0d, got %0d",
                   $signed(want.upper), $signed(m_axis_tdata[63:32]));
            err_count++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(reg_addr_e addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      REG_CLAMP: cfg_clamp = data[0];
      REG_TOL: cfg_tol = data[15:0];
      default: ;
    endcase
  endtask

  task automatic push_joint(opcode_e op, logic signed [31:0] vel, logic signed [31:0] acc,
                            logic signed [31:0] jerk, logic [30:0] lim,
                            logic signed [31:0] scale, logic signed [31:0] rate,
                            logic last);
    joint_t j;
    j.op = op;
    j.vel = vel;
    j.acc = acc;
    j.jerk = jerk;
    j.lim = lim;
    j.scale = scale;
    j.rate = rate;
    j.last = last;
    joint_queue.push_back(j);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0: return W_MIN;
          1: return W_MAX;
          2: return 32'd0;
          default: return Q_ONE;
        endcase
      end
      default: return $signed($urandom) >>> $urandom_range(30, 12);
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    logic [31:0] v;
    case ($urandom_range(9))
      0: return 32'd0;
      1: begin
        v = $urandom_range(8);
        return $urandom_range(1) ? -v : v;
      end
      default: return rand_q();
    endcase
  endfunction

  function automatic opcode_e rand_op();
    return ($urandom_range(9) == 0) ? OP_SPARE : opcode_e'($urandom_range(2));
  endfunction

  task automatic add_runs(int n_items);
    int count;
    int run_len;
    opcode_e run_op;
    count = 0;
    while (count < n_items) begin
      run_len = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
      run_op = rand_op();
      for (int k = 0; k < run_len; k++) begin
        push_joint(($urandom_range(4) == 0) ? rand_op() : run_op,
                   rand_vel(), rand_q(), rand_q(),
                   ($urandom_range(3) == 0) ? 31'($urandom)
                                            : 31'($urandom >> $urandom_range(13, 28)),
                   rand_q(), rand_q(), k == run_len - 1);
      end
      count += run_len;
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (joint_queue.size() != 0 || s_axis_tvalid || bounds_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_CLAMP, 32'd1);
    write_reg(REG_TOL, 32'd0);
    set_idling(0, 0);
    push_joint(OP_VEL, Q_ONE, 0, 0, 31'h8000, 0, 0, 1'b1);
    push_joint(OP_VEL, 0, 0, 0, 31'h10000, 0, 0, 1'b1);
    push_joint(OP_VEL, 32'sd1, 0, 0, LIM_MAX, 0, 0, 1'b1);
    push_joint(OP_VEL, W_MIN, 0, 0, 31'd0, 0, 0, 1'b1);
    push_joint(OP_ACC, W_MAX, W_MAX, 0, LIM_MAX, W_MIN, 0, 1'b1);
    push_joint(OP_ACC, -Q_ONE, -Q_ONE, 0, 31'h10000, 2 * Q_ONE, 0, 1'b1);
    push_joint(OP_JERK, Q_ONE, W_MAX, W_MAX, 31'd0, W_MAX, W_MAX, 1'b1);
    push_joint(OP_JERK, -Q_ONE, W_MIN, W_MIN, LIM_MAX, W_MIN, W_MAX, 1'b1);
    push_joint(OP_JERK, 3 * Q_ONE, 2 * Q_ONE, Q_ONE, 31'h40000, Q_ONE / 2, -Q_ONE, 1'b1);
    push_joint(OP_SPARE, Q_ONE, 0, 0, 31'h10000, 0, 0, 1'b1);
    push_joint(OP_VEL, 2 * Q_ONE, 0, 0, 31'h10000, 0, 0, 1'b0);
    push_joint(OP_ACC, Q_ONE, Q_ONE, 0, 31'h30000, Q_ONE, 0, 1'b0);
    push_joint(OP_JERK, -2 * Q_ONE, Q_ONE, -Q_ONE, 31'h50000, Q_ONE, Q_ONE, 1'b1);
    push_joint(OP_ACC, Q_ONE, 10 * Q_ONE, 0, 31'h10000, Q_ONE, 0, 1'b0);
    push_joint(OP_ACC, Q_ONE, -10 * Q_ONE, 0, 31'h10000, Q_ONE, 0, 1'b1);
    push_joint(OP_ACC, Q_ONE / 4, -Q_ONE, 0, 31'h8000, Q_ONE, 0, 1'b0);
    push_joint(OP_VEL, 4 * Q_ONE, 0, 0, 31'h20000, 0, 0, 1'b1);
    push_joint(OP_VEL, 0, W_MAX, W_MIN, LIM_MAX, W_MAX, W_MIN, 1'b0);
    push_joint(OP_VEL, 0, 0, 0, 31'd0, 0, 0, 1'b1);
    settle();

    write_reg(REG_CLAMP, 32'd0);
    write_reg(REG_TOL, 32'd1);
    set_idling(0, 0);
    add_runs(180);
    settle();

    write_reg(REG_CLAMP, 32'd1);
    write_reg(REG_TOL, 32'd65535);
    set_idling(50, 0);
    add_runs(160);
    settle();

    write_reg(REG_CLAMP, 32'd0);
    write_reg(REG_TOL, 32'd0);
    set_idling(0, 50);
    add_runs(160);
    settle();

    write_reg(REG_CLAMP, 32'd1);
    write_reg(REG_TOL, $urandom_range(65535));
    set_idling(15, 15);
    add_runs(180);
    settle();

    write_reg(REG_CLAMP, $urandom_range(1));
    write_reg(REG_TOL, $urandom_range(256));
    set_idling(0, 0);
    hold_req = hold_req + 1;
    add_runs(80);
    settle();

    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
